/* rtl/mik_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mik_pkg: shared types and Morse table for the identifier keyer
// Request and segment structs, element pattern type, code lookup.
// ----------------------------------------------------------------------------
package mik_pkg;

    localparam int MaxElems = 5;
    localparam int CountW   = $clog2(MaxElems + 1);

    localparam logic [1:0] LenDot  = 2'd1;
    localparam logic [1:0] LenDash = 2'd3;
    localparam logic [1:0] LenGap  = 2'd1;
    localparam logic [1:0] LenWord = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first_char;
        logic       last_char;
    } char_req_t;

    typedef struct packed {
        logic       key_down;
        logic [1:0] length_units;
        logic       end_of_run;
    } seg_t;

    // element pattern: first element in bit 0, a one is a dash
    typedef struct packed {
        logic                mapped;
        logic [CountW-1:0]   count;
        logic [MaxElems-1:0] pattern;
    } code_t;

    function automatic code_t morse_code(input logic [7:0] c);
        code_t r;
        r = '{mapped: 1'b1, count: CountW'(5), pattern: '0};
        case (c)
            8'h41: begin r.count = CountW'(2); r.pattern = 5'b00010; end
            8'h42: begin r.count = CountW'(4); r.pattern = 5'b00001; end
            8'h43: begin r.count = CountW'(4); r.pattern = 5'b00101; end
            8'h44: begin r.count = CountW'(3); r.pattern = 5'b00001; end
            8'h45: begin r.count = CountW'(1); r.pattern = 5'b00000; end
            8'h46: begin r.count = CountW'(4); r.pattern = 5'b00100; end
            8'h47: begin r.count = CountW'(3); r.pattern = 5'b00011; end
            8'h48: begin r.count = CountW'(4); r.pattern = 5'b00000; end
            8'h49: begin r.count = CountW'(2); r.pattern = 5'b00000; end
            8'h4A: begin r.count = CountW'(4); r.pattern = 5'b01110; end
            8'h4B: begin r.count = CountW'(3); r.pattern = 5'b00101; end
            8'h4C: begin r.count = CountW'(4); r.pattern = 5'b00010; end
            8'h4D: begin r.count = CountW'(2); r.pattern = 5'b00011; end
            8'h4E: begin r.count = CountW'(2); r.pattern = 5'b00001; end
            8'h4F: begin r.count = CountW'(3); r.pattern = 5'b00111; end
            8'h50: begin r.count = CountW'(4); r.pattern = 5'b00110; end
            8'h51: begin r.count = CountW'(4); r.pattern = 5'b01011; end
            8'h52: begin r.count = CountW'(3); r.pattern = 5'b00010; end
            8'h53: begin r.count = CountW'(3); r.pattern = 5'b00000; end
            8'h54: begin r.count = CountW'(1); r.pattern = 5'b00001; end
            8'h55: begin r.count = CountW'(3); r.pattern = 5'b00100; end
            8'h56: begin r.count = CountW'(4); r.pattern = 5'b01000; end
            8'h57: begin r.count = CountW'(3); r.pattern = 5'b00110; end
            8'h58: begin r.count = CountW'(4); r.pattern = 5'b01001; end
            8'h59: begin r.count = CountW'(4); r.pattern = 5'b01101; end
            8'h5A: begin r.count = CountW'(4); r.pattern = 5'b00011; end
            8'h30: r.pattern = 5'b11111;
            8'h31: r.pattern = 5'b11110;
            8'h32: r.pattern = 5'b11100;
            8'h33: r.pattern = 5'b11000;
            8'h34: r.pattern = 5'b10000;
            8'h35: r.pattern = 5'b00000;
            8'h36: r.pattern = 5'b00001;
            8'h37: r.pattern = 5'b00011;
            8'h38: r.pattern = 5'b00111;
            8'h39: r.pattern = 5'b01111;
            default: r = '{mapped: 1'b0, count: '0, pattern: '0};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/mik_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mik_lookup: character decoder
// Maps an ASCII code to its element count and dot/dash pattern.
// ----------------------------------------------------------------------------
module mik_lookup (
    input  wire logic [7:0]     char_code,
    output mik_pkg::code_t      code
);
    import mik_pkg::*;

    always_comb
    begin
        code = morse_code(char_code);
    end

endmodule
`default_nettype wire

/* rtl/mik_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mik_sequencer: element shift register and segment sequencer
// Holds one request and steps out one key segment per advance.
// ----------------------------------------------------------------------------
module mik_sequencer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire mik_pkg::char_req_t req,
    input  wire mik_pkg::code_t     code,
    input  wire logic               advance,
    output logic                    busy,
    output mik_pkg::seg_t           seg
);
    import mik_pkg::*;

    logic                lead_reg, lead_next;
    logic                gap_reg, gap_next;
    logic                trail_reg, trail_next;
    logic [CountW-1:0]   cnt_reg, cnt_next;
    logic [MaxElems-1:0] pat_reg, pat_next;
    logic                elems_left;

    assign elems_left = (cnt_reg != '0);
    assign busy       = lead_reg | gap_reg | elems_left | trail_reg;

    // segment on offer from the current state
    always_comb
    begin
        seg = '{key_down: 1'b0, length_units: LenWord, end_of_run: 1'b1};
        if (lead_reg)
        begin
            seg.end_of_run = gap_reg | elems_left | trail_reg;
            seg.end_of_run = ~seg.end_of_run;
        end
        else if (gap_reg)
        begin
            seg.length_units = LenGap;
            seg.end_of_run   = ~(elems_left | trail_reg);
        end
        else if (elems_left)
        begin
            seg.key_down     = 1'b1;
            seg.length_units = pat_reg[0] ? LenDash : LenDot;
            seg.end_of_run   = ~((cnt_reg > CountW'(1)) | trail_reg);
        end
    end

    always_comb
    begin
        lead_next  = lead_reg;
        gap_next   = gap_reg;
        trail_next = trail_reg;
        cnt_next   = cnt_reg;
        pat_next   = pat_reg;
        if (load)
        begin
            lead_next  = req.first_char;
            gap_next   = 1'b0;
            cnt_next   = code.mapped ? code.count : '0;
            pat_next   = code.pattern;
            trail_next = code.mapped & ~req.last_char;
        end
        else if (advance && busy)
        begin
            if (lead_reg)
            begin
                lead_next = 1'b0;
            end
            else if (gap_reg)
            begin
                gap_next = 1'b0;
            end
            else if (elems_left)
            begin
                // advance one element, queue the inner gap if more follow
                pat_next = {1'b0, pat_reg[MaxElems-1:1]};
                cnt_next = cnt_reg - CountW'(1);
                gap_next = (cnt_reg > CountW'(1));
            end
            else
            begin
                trail_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg  <= 1'b0;
            gap_reg   <= 1'b0;
            trail_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            lead_reg  <= lead_next;
            gap_reg   <= gap_next;
            trail_reg <= trail_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

endmodule
`default_nettype wire

/* rtl/morse_id_keyer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_id_keyer_unit: Morse identifier keyer
// Turns identifier characters into key-down / key-up segments in dot units.
// ----------------------------------------------------------------------------
// Usage:
//   char channel (char_valid / char_stall / char_data) takes one request per
//   ASCII character with its first / last flags. seg channel
//   (seg_valid / seg_stall / seg_data) returns the key segments of that
//   character in order; end_of_run marks the last one.
//   A request is held in the element shift register, which steps out one
//   segment per cycle into the output register whenever the output
//   register is free. A character of n segments (0 to 11) keeps char_stall
//   high until the sequencer has stepped out all n of them.
//   A character that yields no segment is taken with no stall.
//   While seg_stall is high the output register holds and the sequencer
//   waits; the next request is taken as soon as the sequencer has emptied,
//   even if its last segment still waits in the output register.
//   Reset clears the sequencer and the output valid; nothing is pending.
// ----------------------------------------------------------------------------
module morse_id_keyer_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_stall,
    input  wire mik_pkg::char_req_t char_data,
    output logic                    seg_valid,
    input  wire logic               seg_stall,
    output mik_pkg::seg_t           seg_data
);
    import mik_pkg::*;

    code_t code;
    seg_t  seg_offer;
    logic  busy;
    logic  load;
    logic  slot_free;
    logic  emit;
    logic  seg_valid_reg, seg_valid_next;
    seg_t  seg_data_reg;

    assign char_stall = busy;
    assign load       = char_valid & ~busy;
    assign slot_free  = ~seg_valid_reg | ~seg_stall;
    assign emit       = busy & slot_free;

    mik_lookup u_lookup (
        .char_code (char_data.char_code),
        .code      (code)
    );

    mik_sequencer u_sequencer (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .req     (char_data),
        .code    (code),
        .advance (slot_free),
        .busy    (busy),
        .seg     (seg_offer)
    );

    always_comb
    begin
        seg_valid_next = seg_valid_reg & seg_stall;
        if (emit)
        begin
            seg_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            seg_data_reg <= seg_offer;
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg_data  = seg_data_reg;

    // a request with the lead-in always keeps the sequencer busy next cycle
    a_lead_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && char_data.first_char) |=> char_stall)
        else $error("lead-in request did not occupy the sequencer");

    // a segment that is not the last leaves more work behind
    a_more_after : assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !seg_offer.end_of_run) |=> busy)
        else $error("sequencer emptied before end of run");

    // the closing segment empties the sequencer
    a_end_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (emit && seg_offer.end_of_run) |=> !busy)
        else $error("sequencer still busy after end of run");

endmodule
`default_nettype wire
